[hdl/vad_pkg.sv]
// ----------------------------------------------------------------------------
// vad_pkg: shared constants, types and tables
// Widths of the angle datapath, pipeline side band and the CORDIC
// degree arctangent table built at elaboration.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MAG_W           = 32;   // narrowed component magnitude
  localparam int V_W             = 64;   // dot / cross magnitudes
  localparam int SQ_W            = 128;  // squared sums
  localparam int RAD_W           = 120;  // normalized radicand
  localparam int ROOT_W          = 60;   // square root and scaled dot
  localparam int CORD_W          = 64;   // CORDIC x, y, z
  localparam int ITERS           = 48;
  localparam int DEG_FRAC        = 48;
  localparam int OUT_FRAC        = 16;
  localparam int ANGLE_W         = 24;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 24'd11796480;
  localparam logic [CORD_W-1:0]  FULL_DEG  = 64'd180 << DEG_FRAC;

  typedef struct packed {
    logic zero;
    logic dot_neg;
  } tag_t;

  typedef logic [ITERS-1:0][CORD_W-1:0] rom_t;

  function automatic logic [127:0] long_div(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    logic [64:0]  r;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q60 radians by series
  function automatic logic [63:0] atan_inv_q60(input logic [63:0] n);
    logic [63:0]  t;
    logic [63:0]  sum;
    logic [63:0]  k;
    logic [63:0]  term;
    logic [127:0] q;
    logic         sub;
    q   = long_div(128'(1) << 60, n);
    t   = q[63:0];
    sum = '0;
    k   = '0;
    sub = 1'b0;
    while (t != '0) begin
      q    = long_div(128'(t), (k << 1) + 64'd1);
      term = q[63:0];
      sum  = sub ? sum - term : sum + term;
      sub  = ~sub;
      k    = k + 64'd1;
      q    = long_div(128'(t), n);
      q    = long_div(q, n);
      t    = q[63:0];
    end
    return sum;
  endfunction

  function automatic rom_t build_rom();
    logic [63:0]  quarter;
    logic [63:0]  pi;
    logic [63:0]  a;
    logic [127:0] q;
    rom_t         rom;
    quarter = (atan_inv_q60(64'd5) << 2) - atan_inv_q60(64'd239);
    pi      = quarter << 2;
    for (int i = 0; i < ITERS; i++) begin
      a      = (i == 0) ? quarter : atan_inv_q60(64'd1 << i);
      q      = long_div((128'(a) * 128'd180) << DEG_FRAC, pi);
      rom[i] = q[63:0];
    end
    return rom;
  endfunction

  localparam rom_t DEG_ROM = build_rom();

endpackage

[hdl/vad_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// vad_sqrt_pipe: pipelined integer square root
// Restoring square root of a 120-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module vad_sqrt_pipe import vad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [ROOT_W-1:0] in_dm,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [ROOT_W-1:0] out_dm,
  output tag_t              out_tag
);

  logic [ROOT_W-1:0] vld;
  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] res_q  [ROOT_W];
  logic [ROOT_W-1:0] dm_q   [ROOT_W];
  tag_t              tag_q  [ROOT_W];
  logic [RAD_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] res_next [ROOT_W];

  always_comb begin
    logic [RAD_W-1:0]  ri;
    logic [ROOT_W-1:0] si;
    logic [RAD_W:0]    trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        ri = in_rad;
        si = '0;
      end else begin
        ri = rem_q[k-1];
        si = res_q[k-1];
      end
      trial = ((RAD_W+1)'(si) << (ROOT_W - k)) | ((RAD_W+1)'(1) << (2 * (ROOT_W - 1 - k)));
      if ({1'b0, ri} >= trial) begin
        rem_next[k] = RAD_W'({1'b0, ri} - trial);
        res_next[k] = si | (ROOT_W'(1) << (ROOT_W - 1 - k));
      end else begin
        rem_next[k] = ri;
        res_next[k] = si;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_q[k] <= rem_next[k];
        res_q[k] <= res_next[k];
        dm_q[k]  <= (k == 0) ? in_dm : dm_q[k-1];
        tag_q[k] <= (k == 0) ? in_tag : tag_q[k-1];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = res_q[ROOT_W-1];
  assign out_dm    = dm_q[ROOT_W-1];
  assign out_tag   = tag_q[ROOT_W-1];

endmodule

[hdl/vad_cordic_pipe.sv]
// ----------------------------------------------------------------------------
// vad_cordic_pipe: pipelined vectoring CORDIC
// Drives y to zero and accumulates the angle in Q48 degrees, one
// iteration per stage.
// ----------------------------------------------------------------------------
module vad_cordic_pipe import vad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [ROOT_W-1:0]        in_x,
  input  logic [ROOT_W-1:0]        in_y,
  input  tag_t                     in_tag,
  output logic                     out_valid,
  output logic signed [CORD_W-1:0] out_z,
  output tag_t                     out_tag
);

  logic [ITERS-1:0]         vld;
  logic signed [CORD_W-1:0] x_q [ITERS];
  logic signed [CORD_W-1:0] y_q [ITERS];
  logic signed [CORD_W-1:0] z_q [ITERS];
  tag_t                     tag_q [ITERS];
  logic signed [CORD_W-1:0] x_next [ITERS];
  logic signed [CORD_W-1:0] y_next [ITERS];
  logic signed [CORD_W-1:0] z_next [ITERS];

  always_comb begin
    logic signed [CORD_W-1:0] xi;
    logic signed [CORD_W-1:0] yi;
    logic signed [CORD_W-1:0] zi;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    for (int k = 0; k < ITERS; k++) begin
      if (k == 0) begin
        xi = $signed(CORD_W'(in_x));
        yi = $signed(CORD_W'(in_y));
        zi = '0;
      end else begin
        xi = x_q[k-1];
        yi = y_q[k-1];
        zi = z_q[k-1];
      end
      dx = yi >>> k;
      dy = xi >>> k;
      if (yi > 0) begin
        x_next[k] = xi + dx;
        y_next[k] = yi - dy;
        z_next[k] = zi + $signed(DEG_ROM[k]);
      end else begin
        x_next[k] = xi - dx;
        y_next[k] = yi + dy;
        z_next[k] = zi - $signed(DEG_ROM[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ITERS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ITERS; k++) begin
        x_q[k]   <= x_next[k];
        y_q[k]   <= y_next[k];
        z_q[k]   <= z_next[k];
        tag_q[k] <= (k == 0) ? in_tag : tag_q[k-1];
      end
    end
  end

  assign out_valid = vld[ITERS-1];
  assign out_z     = z_q[ITERS-1];
  assign out_tag   = tag_q[ITERS-1];

endmodule

[hdl/vector_angle_degrees_core.sv]
// ----------------------------------------------------------------------------
// vector_angle_degrees_core: angle between two 3D vectors in degrees
// Throughput: one word per cycle while in_ready is high (120 register stages
// in all); in_ready drops while the skid register holds a result.
// Depth: 10 front stages (products, squares, normalize), 60 square root
// stages, 48 CORDIC stages, one rounding stage, one output register.
// A skid register behind the output lets one more word leave the pipeline
// while a result waits. rst clears all valid bits; no data is reset.
// ----------------------------------------------------------------------------
module vector_angle_degrees_core import vad_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ANGLE_W-1:0]            angle_deg,
  output logic                          zero_length
);

  localparam int EXT_W  = (COORD_WIDTH > MAG_W) ? COORD_WIDTH : MAG_W;
  localparam int MAX_SH = EXT_W - MAG_W;
  localparam int SH_W   = (MAX_SH > 0) ? $clog2(MAX_SH + 1) : 1;
  localparam int P_W    = 2 * (MAG_W + 1);
  localparam int SUM_W  = P_W + 2;
  localparam int CH_W   = 16;
  localparam int N_CH   = SQ_W / CH_W;
  localparam int LZ_W   = $clog2(SQ_W) + 1;
  localparam int HALF_W = V_W / 2;

  logic en;
  logic skid_v;
  logic [ANGLE_W-1:0] skid_angle;
  logic skid_zero;

  assign en       = ~skid_v;
  assign in_ready = en;

  // stage 1: magnitudes, zero test, per-vector max
  logic [COORD_WIDTH-1:0] ua [3];
  logic [COORD_WIDTH-1:0] ub [3];
  logic [EXT_W-1:0] ma [3];
  logic [EXT_W-1:0] mb [3];
  logic [EXT_W-1:0] maxa;
  logic [EXT_W-1:0] maxb;

  assign ua[0] = first_x;
  assign ua[1] = first_y;
  assign ua[2] = first_z;
  assign ub[0] = second_x;
  assign ub[1] = second_y;
  assign ub[2] = second_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = EXT_W'(ua[i][COORD_WIDTH-1] ? COORD_WIDTH'(~ua[i] + 1'b1) : ua[i]);
      mb[i] = EXT_W'(ub[i][COORD_WIDTH-1] ? COORD_WIDTH'(~ub[i] + 1'b1) : ub[i]);
    end
    maxa = ma[0];
    maxb = mb[0];
    for (int i = 1; i < 3; i++) begin
      if (ma[i] > maxa) maxa = ma[i];
      if (mb[i] > maxb) maxb = mb[i];
    end
  end

  logic s1_v;
  logic [EXT_W-1:0] s1_ma [3];
  logic [EXT_W-1:0] s1_mb [3];
  logic s1_na [3];
  logic s1_nb [3];
  logic s1_zero;
  logic [EXT_W-1:0] s1_maxa;
  logic [EXT_W-1:0] s1_maxb;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ma[i] <= ma[i];
        s1_mb[i] <= mb[i];
        s1_na[i] <= ua[i][COORD_WIDTH-1];
        s1_nb[i] <= ub[i][COORD_WIDTH-1];
      end
      s1_maxa <= maxa;
      s1_maxb <= maxb;
      s1_zero <= (~|{first_x, first_y, first_z}) | (~|{second_x, second_y, second_z});
    end
  end

  // stage 2: narrow each vector to at most 2^31, back to signed
  logic [SH_W-1:0] sha;
  logic [SH_W-1:0] shb;
  logic signed [MAG_W:0] na [3];
  logic signed [MAG_W:0] nb [3];

  always_comb begin
    logic [MAG_W-1:0] m;
    sha = '0;
    shb = '0;
    for (int s = MAX_SH; s >= 0; s--) begin
      if ((s1_maxa >> s) <= EXT_W'(64'h8000_0000)) sha = SH_W'(s);
      if ((s1_maxb >> s) <= EXT_W'(64'h8000_0000)) shb = SH_W'(s);
    end
    for (int i = 0; i < 3; i++) begin
      m     = MAG_W'(s1_ma[i] >> sha);
      na[i] = s1_na[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      m     = MAG_W'(s1_mb[i] >> shb);
      nb[i] = s1_nb[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  logic s2_v;
  logic s2_zero;
  logic signed [MAG_W:0] s2_a [3];
  logic signed [MAG_W:0] s2_b [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a    <= na;
      s2_b    <= nb;
      s2_zero <= s1_zero;
    end
  end

  // stage 3: nine products
  logic s3_v;
  logic s3_zero;
  logic signed [P_W-1:0] s3_p [9];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p[0] <= s2_a[0] * s2_b[0];
      s3_p[1] <= s2_a[1] * s2_b[1];
      s3_p[2] <= s2_a[2] * s2_b[2];
      s3_p[3] <= s2_a[1] * s2_b[2];
      s3_p[4] <= s2_a[2] * s2_b[1];
      s3_p[5] <= s2_a[2] * s2_b[0];
      s3_p[6] <= s2_a[0] * s2_b[2];
      s3_p[7] <= s2_a[0] * s2_b[1];
      s3_p[8] <= s2_a[1] * s2_b[0];
      s3_zero <= s2_zero;
    end
  end

  // stage 4: dot and cross, to sign and magnitude
  logic signed [SUM_W-1:0] dot_s;
  logic signed [SUM_W-1:0] crs [3];

  always_comb begin
    dot_s = SUM_W'(s3_p[0]) + SUM_W'(s3_p[1]) + SUM_W'(s3_p[2]);
    for (int i = 0; i < 3; i++) begin
      crs[i] = SUM_W'(s3_p[3+2*i]) - SUM_W'(s3_p[4+2*i]);
    end
  end

  logic s4_v;
  tag_t s4_tag;
  logic [V_W-1:0] s4_val [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_val[i] <= V_W'(crs[i][SUM_W-1] ? -crs[i] : crs[i]);
      end
      s4_val[3]      <= V_W'(dot_s[SUM_W-1] ? -dot_s : dot_s);
      s4_tag.dot_neg <= dot_s[SUM_W-1];
      s4_tag.zero    <= s3_zero;
    end
  end

  // stage 5: partial products of the squares
  logic s5_v;
  tag_t s5_tag;
  logic [V_W-1:0] s5_dm;
  logic [V_W-1:0] s5_ll [4];
  logic [V_W-1:0] s5_lh [4];
  logic [V_W-1:0] s5_hh [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s5_ll[i] <= s4_val[i][HALF_W-1:0] * s4_val[i][HALF_W-1:0];
        s5_lh[i] <= s4_val[i][HALF_W-1:0] * s4_val[i][V_W-1:HALF_W];
        s5_hh[i] <= s4_val[i][V_W-1:HALF_W] * s4_val[i][V_W-1:HALF_W];
      end
      s5_dm  <= s4_val[3];
      s5_tag <= s4_tag;
    end
  end

  // stage 6: squares
  logic s6_v;
  tag_t s6_tag;
  logic [V_W-1:0] s6_dm;
  logic [SQ_W-1:0] s6_sq [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s6_sq[i] <= {s5_hh[i], {V_W{1'b0}}} + (SQ_W'(s5_lh[i]) << (HALF_W + 1))
                    + SQ_W'(s5_ll[i]);
      end
      s6_dm  <= s5_dm;
      s6_tag <= s5_tag;
    end
  end

  // stage 7: |a x b|^2 and the larger of the two squares
  logic [SQ_W-1:0] c2_sum;
  assign c2_sum = s6_sq[0] + s6_sq[1] + s6_sq[2];

  logic s7_v;
  tag_t s7_tag;
  logic [V_W-1:0] s7_dm;
  logic [SQ_W-1:0] s7_c2;
  logic [SQ_W-1:0] s7_big;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_c2  <= c2_sum;
      s7_big <= (c2_sum < s6_sq[3]) ? s6_sq[3] : c2_sum;
      s7_dm  <= s6_dm;
      s7_tag <= s6_tag;
    end
  end

  // stage 8: leading zeros per 16-bit chunk
  logic [N_CH-1:0] ch_nz;
  logic [3:0] ch_lz [N_CH];

  always_comb begin
    logic [CH_W-1:0] chunk;
    for (int j = 0; j < N_CH; j++) begin
      chunk    = s7_big[CH_W*j +: CH_W];
      ch_nz[j] = |chunk;
      ch_lz[j] = '0;
      for (int b = 0; b < CH_W; b++) begin
        if (chunk[b]) ch_lz[j] = 4'(CH_W - 1 - b);
      end
    end
  end

  logic s8_v;
  tag_t s8_tag;
  logic [V_W-1:0] s8_dm;
  logic [SQ_W-1:0] s8_c2;
  logic [N_CH-1:0] s8_nz;
  logic [3:0] s8_lz [N_CH];

  always_ff @(posedge clk) begin
    if (en) begin
      s8_nz  <= ch_nz;
      s8_lz  <= ch_lz;
      s8_c2  <= s7_c2;
      s8_dm  <= s7_dm;
      s8_tag <= s7_tag;
    end
  end

  // stage 9: total leading zeros, rounded down to even
  logic [LZ_W-1:0] lzc;

  always_comb begin
    lzc = LZ_W'(SQ_W);
    for (int j = 0; j < N_CH; j++) begin
      if (s8_nz[j]) lzc = LZ_W'(CH_W * (N_CH - 1 - j)) + LZ_W'(s8_lz[j]);
    end
  end

  logic s9_v;
  tag_t s9_tag;
  logic [V_W-1:0] s9_dm;
  logic [SQ_W-1:0] s9_c2;
  logic [LZ_W-1:0] s9_le;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_le  <= {lzc[LZ_W-1:1], 1'b0};
      s9_c2  <= s8_c2;
      s9_dm  <= s8_dm;
      s9_tag <= s8_tag;
    end
  end

  // stage 10: scale so the larger square has 119..120 bits
  localparam logic [LZ_W-1:0] HEAD = LZ_W'(SQ_W - RAD_W);
  logic [RAD_W-1:0] rad_n;
  logic [ROOT_W-1:0] dm_n;

  always_comb begin
    logic [LZ_W-1:0] amt;
    if (s9_le >= HEAD) begin
      amt   = s9_le - HEAD;
      rad_n = RAD_W'(s9_c2 << amt);
      dm_n  = ROOT_W'(s9_dm << (amt >> 1));
    end else begin
      amt   = HEAD - s9_le;
      rad_n = RAD_W'(s9_c2 >> amt);
      dm_n  = ROOT_W'(s9_dm >> (amt >> 1));
    end
  end

  logic s10_v;
  tag_t s10_tag;
  logic [RAD_W-1:0] s10_rad;
  logic [ROOT_W-1:0] s10_dm;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_rad <= rad_n;
      s10_dm  <= dm_n;
      s10_tag <= s9_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      s6_v  <= 1'b0;
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
    end else if (en) begin
      s1_v  <= in_valid;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v;
      s5_v  <= s4_v;
      s6_v  <= s5_v;
      s7_v  <= s6_v;
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
    end
  end

  // square root of the cross magnitude
  logic sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [ROOT_W-1:0] sq_dm;
  tag_t sq_tag;

  vad_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s10_v),
    .in_rad    (s10_rad),
    .in_dm     (s10_dm),
    .in_tag    (s10_tag),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_dm    (sq_dm),
    .out_tag   (sq_tag)
  );

  // first-quadrant angle
  logic co_v;
  logic signed [CORD_W-1:0] co_z;
  tag_t co_tag;

  vad_cordic_pipe u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .in_x      (sq_dm),
    .in_y      (sq_root),
    .in_tag    (sq_tag),
    .out_valid (co_v),
    .out_z     (co_z),
    .out_tag   (co_tag)
  );

  // stage 11: clamp, fold for negative dot, round to Q16
  localparam logic [CORD_W-1:0] HALF_LSB = CORD_W'(1) << (DEG_FRAC - OUT_FRAC - 1);
  logic [ANGLE_W-1:0] ang_n;

  always_comb begin
    logic [CORD_W-1:0] zc;
    logic [CORD_W-1:0] theta;
    logic [CORD_W-1:0] q;
    if (co_z < 0) begin
      zc = '0;
    end else if (co_z > $signed(FULL_DEG)) begin
      zc = FULL_DEG;
    end else begin
      zc = co_z;
    end
    theta = co_tag.dot_neg ? FULL_DEG - zc : zc;
    q     = (theta + HALF_LSB) >> (DEG_FRAC - OUT_FRAC);
    if (co_tag.zero) begin
      ang_n = '0;
    end else if (q > CORD_W'(ANGLE_MAX)) begin
      ang_n = ANGLE_MAX;
    end else begin
      ang_n = ANGLE_W'(q);
    end
  end

  logic p_v;
  logic [ANGLE_W-1:0] p_angle;
  logic p_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= co_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_angle <= ang_n;
      p_zero  <= co_tag.zero;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        out_valid   <= 1'b1;
        angle_deg   <= skid_angle;
        zero_length <= skid_zero;
        skid_v      <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid   <= p_v;
      angle_deg   <= p_angle;
      zero_length <= p_zero;
    end else if (p_v) begin
      skid_v     <= 1'b1;
      skid_angle <= p_angle;
      skid_zero  <= p_zero;
    end
  end

endmodule
